// ===== sv/annexb_nal_splitter_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the Annex B start code splitter
// Short forms for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef ANNEXB_NAL_SPLITTER_ASSERT_SVH
`define ANNEXB_NAL_SPLITTER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ANBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define ANBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/anbs_pkg.sv =====
// ---------------------------------------------------------------------------
// anbs_pkg
// Shared types and codes of the Annex B start code splitter.
// ---------------------------------------------------------------------------
package anbs_pkg;

  // parse modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_BODY  = 2'd1;
  localparam logic [1:0] MODE_DROP  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DATA  = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;

  // results one input beat can cause
  localparam int MAX_RES   = 4;
  localparam int RES_IDX_W = $clog2(MAX_RES);
  localparam int RES_CNT_W = RES_IDX_W + 1;

  // bundles held between front and back
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = QPTR_W + 1;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic [4:0] utype;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0]      cnt;
    res_t [MAX_RES-1:0]        res;
  } bundle_t;

  typedef struct packed {
    logic    push;
    bundle_t bundle;
  } fq_wr_t;

endpackage

// ===== sv/anbs_front.sv =====
// ---------------------------------------------------------------------------
// anbs_front
// Parses one packet byte per beat and builds the bundle of results it causes.
// ---------------------------------------------------------------------------
module anbs_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [7:0]            in_byte,
  input  logic                  in_packet_end,
  output anbs_pkg::fq_wr_t      fq_wr
);

  logic [1:0] mode_r, mode_nxt;
  logic [1:0] hdr_pos_r, hdr_pos_nxt;
  logic       hdr_nz_r, hdr_nz_nxt;
  logic [1:0] held_cnt_r, held_cnt_nxt;
  logic [4:0] cur_type_r, cur_type_nxt;
  logic       first_pend_r, first_pend_nxt;
  logic [7:0] pend_byte_r, pend_byte_nxt;
  logic       pend_valid_r, pend_valid_nxt;
  logic       pend_first_r, pend_first_nxt;
  anbs_pkg::bundle_t bundle;

  function automatic anbs_pkg::bundle_t add_res(
    anbs_pkg::bundle_t bd, logic [7:0] data, logic first, logic last,
    logic [4:0] utype, logic [1:0] status);
    anbs_pkg::bundle_t r;
    r = bd;
    if (r.cnt < anbs_pkg::RES_CNT_W'(anbs_pkg::MAX_RES)) begin
      r.res[r.cnt[anbs_pkg::RES_IDX_W-1:0]] = '{data, first, last, utype, status};
      r.cnt = r.cnt + 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    logic [1:0] nz;
    logic       push_b, do_close, do_stat, go_start, go_body;
    logic [1:0] stat;
    logic [7:0] pb;
    logic       pv, pf, fp;
    logic [4:0] ct;
    logic       b_zero, b_one, e;
    anbs_pkg::bundle_t bd;

    b_zero = (in_byte == anbs_pkg::BYTE_ZERO);
    b_one  = (in_byte == anbs_pkg::BYTE_ONE);
    e      = in_packet_end;

    nz = 2'd0; push_b = 1'b0; do_close = 1'b0; do_stat = 1'b0;
    go_start = 1'b0; go_body = 1'b0; stat = anbs_pkg::ST_DATA;
    mode_nxt = mode_r; hdr_pos_nxt = hdr_pos_r; hdr_nz_nxt = hdr_nz_r;
    held_cnt_nxt = held_cnt_r;

    case (mode_r)
      anbs_pkg::MODE_BODY: begin
        if (b_one && held_cnt_r >= 2'd2) begin
          do_close = 1'b1;
          if (e) begin
            // keep the extra leading zero of a four-byte code as data
            nz = (held_cnt_r == 2'd3) ? 2'd1 : 2'd0;
            do_stat = 1'b1;
            stat = anbs_pkg::ST_SHORT;
            go_start = 1'b1;
          end else begin
            held_cnt_nxt = 2'd0;
          end
        end else if (b_zero) begin
          if (e) begin
            nz = (held_cnt_r == 2'd3) ? 2'd3 : held_cnt_r + 2'd1;
            do_close = 1'b1;
            go_start = 1'b1;
          end else if (held_cnt_r == 2'd3) begin
            nz = 2'd1;
          end else begin
            held_cnt_nxt = held_cnt_r + 2'd1;
          end
        end else begin
          // drop one of three held zeros at packet end
          nz = (e && held_cnt_r == 2'd3) ? 2'd2 : held_cnt_r;
          push_b = 1'b1;
          held_cnt_nxt = 2'd0;
          if (e) begin
            do_close = 1'b1;
            go_start = 1'b1;
          end
        end
      end
      anbs_pkg::MODE_DROP: begin
        if (e) go_start = 1'b1;
      end
      default: begin
        if (hdr_pos_r < 2'd2) begin
          hdr_nz_nxt = (hdr_pos_r == 2'd0) ? !b_zero : (hdr_nz_r | !b_zero);
          if (e) begin
            do_stat = 1'b1;
            stat = anbs_pkg::ST_SHORT;
            go_start = 1'b1;
          end else begin
            hdr_pos_nxt = hdr_pos_r + 2'd1;
          end
        end else if (hdr_pos_r == 2'd2) begin
          if (e) begin
            do_stat = 1'b1;
            stat = anbs_pkg::ST_SHORT;
            go_start = 1'b1;
          end else if (hdr_nz_r || !(b_one || b_zero)) begin
            do_stat = 1'b1;
            stat = anbs_pkg::ST_BAD;
            mode_nxt = anbs_pkg::MODE_DROP;
            hdr_pos_nxt = 2'd0;
          end else if (b_one) begin
            go_body = 1'b1;
          end else begin
            hdr_pos_nxt = 2'd3;
          end
        end else begin
          if (b_one && !e) begin
            go_body = 1'b1;
          end else begin
            do_stat = 1'b1;
            stat = anbs_pkg::ST_BAD;
            if (e) begin
              go_start = 1'b1;
            end else begin
              mode_nxt = anbs_pkg::MODE_DROP;
              hdr_pos_nxt = 2'd0;
            end
          end
        end
      end
    endcase

    // carry out the data pushes in order: held zeros, the byte, close, status
    bd = '0;
    pb = pend_byte_r; pv = pend_valid_r; pf = pend_first_r;
    fp = first_pend_r; ct = cur_type_r;
    for (int i = 0; i < 3; i++) begin
      if (i < int'(nz)) begin
        if (pv) bd = add_res(bd, pb, pf, 1'b0, ct, anbs_pkg::ST_DATA);
        pf = fp;
        if (fp) begin
          ct = 5'd0;
          fp = 1'b0;
        end
        pb = anbs_pkg::BYTE_ZERO;
        pv = 1'b1;
      end
    end
    if (push_b) begin
      if (pv) bd = add_res(bd, pb, pf, 1'b0, ct, anbs_pkg::ST_DATA);
      pf = fp;
      if (fp) begin
        ct = in_byte[4:0];
        fp = 1'b0;
      end
      pb = in_byte;
      pv = 1'b1;
    end
    if (do_close) begin
      if (pv) bd = add_res(bd, pb, pf, 1'b1, ct, anbs_pkg::ST_DATA);
      pv = 1'b0;
      fp = 1'b1;
    end
    if (do_stat) bd = add_res(bd, 8'd0, 1'b0, 1'b0, 5'd0, stat);
    if (go_start) begin
      mode_nxt = anbs_pkg::MODE_START;
      hdr_pos_nxt = 2'd0;
      held_cnt_nxt = 2'd0;
    end
    if (go_body) begin
      mode_nxt = anbs_pkg::MODE_BODY;
      hdr_pos_nxt = 2'd0;
      held_cnt_nxt = 2'd0;
      pv = 1'b0;
      fp = 1'b1;
    end

    pend_byte_nxt = pb; pend_valid_nxt = pv; pend_first_nxt = pf;
    first_pend_nxt = fp; cur_type_nxt = ct;
    bundle = bd;
  end

  assign fq_wr.push   = accept && (bundle.cnt != '0);
  assign fq_wr.bundle = bundle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= anbs_pkg::MODE_START;
      hdr_pos_r    <= 2'd0;
      held_cnt_r   <= 2'd0;
      first_pend_r <= 1'b1;
      pend_valid_r <= 1'b0;
      cur_type_r   <= 5'd0;
    end else if (accept) begin
      mode_r       <= mode_nxt;
      hdr_pos_r    <= hdr_pos_nxt;
      held_cnt_r   <= held_cnt_nxt;
      first_pend_r <= first_pend_nxt;
      pend_valid_r <= pend_valid_nxt;
      cur_type_r   <= cur_type_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hdr_nz_r     <= hdr_nz_nxt;
      pend_byte_r  <= pend_byte_nxt;
      pend_first_r <= pend_first_nxt;
    end
  end

endmodule

// ===== sv/anbs_back.sv =====
// ---------------------------------------------------------------------------
// anbs_back
// Queues result bundles and hands their results out one beat at a time.
// ---------------------------------------------------------------------------
module anbs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  anbs_pkg::fq_wr_t  fq_wr,
  output logic              full,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [7:0]        out_byte,
  output logic              out_unit_first,
  output logic              out_unit_last,
  output logic [4:0]        out_unit_type,
  output logic [1:0]        out_status
);

  anbs_pkg::bundle_t q_r [anbs_pkg::QDEPTH];
  logic [anbs_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [anbs_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic [anbs_pkg::RES_IDX_W-1:0] idx_r;
  anbs_pkg::bundle_t head;
  anbs_pkg::res_t    cur;
  logic pop_ok, head_done, deq;

  assign head      = q_r[rd_ptr_r];
  assign cur       = head.res[idx_r];
  assign out_empty = (cnt_r == '0);
  assign full      = (cnt_r == anbs_pkg::QCNT_W'(anbs_pkg::QDEPTH));
  assign pop_ok    = out_pop && !out_empty;
  assign head_done = ({1'b0, idx_r} + 1'b1) == head.cnt;
  assign deq       = pop_ok && head_done;
  assign cnt_nxt   = cnt_r + anbs_pkg::QCNT_W'(fq_wr.push) - anbs_pkg::QCNT_W'(deq);

  assign out_byte       = cur.data;
  assign out_unit_first = cur.first;
  assign out_unit_last  = cur.last;
  assign out_unit_type  = cur.utype;
  assign out_status     = cur.status;

  always_ff @(posedge clk) begin
    if (fq_wr.push) q_r[wr_ptr_r] <= fq_wr.bundle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      idx_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (fq_wr.push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop_ok) begin
        // advance within the bundle, retire it after its last result
        if (head_done) begin
          idx_r    <= '0;
          rd_ptr_r <= rd_ptr_r + 1'b1;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/annexb_nal_splitter.sv =====
// A packet's bytes are taken at one byte per clock while in_full is low. Each
// byte's results (up to four: unit bytes with start codes removed, or a bad
// start code or short packet report) are formed in the cycle the byte is taken
// and wait in a four-bundle queue; the result side hands out one result per
// clock while out_pop is high. When no earlier bundle waits, the first
// result of a byte is visible the cycle after that byte is taken.
// in_full rises when four bundles wait; the result-side pop rate sets the
// sustained input rate whenever bytes cause more than one result each.
// ---------------------------------------------------------------------------
// annexb_nal_splitter
// Annex B start code parser: splits a packet byte stream into unit bytes.
// ---------------------------------------------------------------------------
module annexb_nal_splitter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_byte,
  input  logic       in_packet_end,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte,
  output logic       out_unit_first,
  output logic       out_unit_last,
  output logic [4:0] out_unit_type,
  output logic [1:0] out_status
);

  `include "annexb_nal_splitter_assert.svh"

  anbs_pkg::fq_wr_t fq_wr;
  logic accept;

  assign accept = in_push && !in_full;

  anbs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_byte       (in_byte),
    .in_packet_end (in_packet_end),
    .fq_wr         (fq_wr)
  );

  anbs_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .fq_wr          (fq_wr),
    .full           (in_full),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_byte       (out_byte),
    .out_unit_first (out_unit_first),
    .out_unit_last  (out_unit_last),
    .out_unit_type  (out_unit_type),
    .out_status     (out_status)
  );

  `ANBS_ASSERT_NOW(a_full_has_results, in_full, !out_empty, "queue full but no result shown")
  `ANBS_ASSERT_NOW(a_push_nonempty, fq_wr.push, fq_wr.bundle.cnt != '0, "empty bundle queued")
  `ANBS_ASSERT_NOW(a_report_clean, !out_empty && out_status != anbs_pkg::ST_DATA, out_byte == 8'd0 && !out_unit_first && !out_unit_last && out_unit_type == 5'd0, "report carries payload")
  `ANBS_ASSERT_NEXT(a_push_shows, fq_wr.push, !out_empty, "queued bundle not shown")

endmodule

// ===== sim/annexb_nal_splitter_tb.sv =====
// ---------------------------------------------------------------------------
// annexb_nal_splitter_tb
// Feeds packets of bytes into the start code splitter: a short scripted set
// (short packets, bad start codes, one good packet) and then random packets,
// mostly well formed with start codes inside the unit, some broken or noise.
// Result beats are checked against scripted reports or an in-bench parser model.
// ---------------------------------------------------------------------------
module annexb_nal_splitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {ROW_MODEL, ROW_QUIET, ROW_BAD, ROW_SHORT} row_kind_t;

  typedef struct {
    logic [7:0] b;
    logic       e;
    row_kind_t  kind;
  } script_row_t;

  localparam int SCRIPT_LEN  = 25;
  localparam int RANDOM_BEATS = 455;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_packet_end;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [7:0] out_byte;
  logic       out_unit_first;
  logic       out_unit_last;
  logic [4:0] out_unit_type;
  logic [1:0] out_status;
  row_kind_t  row_kind = ROW_MODEL;

  int beats_sent = 0;
  int beat_errs  = 0;
  int results_seen = 0;

  anbs_pkg::res_t awaited_beats[$];

  // parser model state
  logic [1:0] pmode      = anbs_pkg::MODE_START;
  logic [7:0] hdr [0:2]  = '{8'h00, 8'h00, 8'h00};
  int         hdr_pos    = 0;
  int         held_zeros = 0;
  logic [4:0] cur_type   = 5'd0;
  logic       open_next  = 1'b1;
  logic [7:0] hold_byte  = 8'h00;
  logic       hold_valid = 1'b0;
  logic       hold_first = 1'b0;
  anbs_pkg::res_t found [anbs_pkg::MAX_RES];
  int         found_n;

  annexb_nal_splitter dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_byte       (in_byte),
    .in_packet_end (in_packet_end),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_byte      (out_byte),
    .out_unit_first(out_unit_first),
    .out_unit_last (out_unit_last),
    .out_unit_type (out_unit_type),
    .out_status    (out_status)
  );

  always #10 clk = ~clk;

  function automatic void add_result(logic [7:0] d, logic f, logic l, logic [4:0] t,
                                     logic [1:0] s);
    if (found_n < anbs_pkg::MAX_RES) begin
      found[found_n].data   = d;
      found[found_n].first  = f;
      found[found_n].last   = l;
      found[found_n].utype  = t;
      found[found_n].status = s;
      found_n++;
    end
  endfunction

  // hold the newest unit byte back until we know whether it closes the unit
  function automatic void take_byte(logic [7:0] b);
    if (hold_valid) add_result(hold_byte, hold_first, 1'b0, cur_type, anbs_pkg::ST_DATA);
    hold_first = open_next;
    if (open_next) begin
      cur_type  = b[4:0];
      open_next = 1'b0;
    end
    hold_byte  = b;
    hold_valid = 1'b1;
  endfunction

  function automatic void finish_unit();
    if (hold_valid) add_result(hold_byte, hold_first, 1'b1, cur_type, anbs_pkg::ST_DATA);
    hold_valid = 1'b0;
    open_next  = 1'b1;
  endfunction

  function automatic void rearm();
    pmode      = anbs_pkg::MODE_START;
    hdr_pos    = 0;
    held_zeros = 0;
  endfunction

  function automatic void enter_unit();
    pmode      = anbs_pkg::MODE_BODY;
    hdr_pos    = 0;
    held_zeros = 0;
    hold_valid = 1'b0;
    open_next  = 1'b1;
  endfunction

  function automatic void go_drop();
    add_result(8'h00, 1'b0, 1'b0, 5'd0, anbs_pkg::ST_BAD);
    pmode   = anbs_pkg::MODE_DROP;
    hdr_pos = 0;
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic e);
    int zeros;
    found_n = 0;
    case (pmode)
      anbs_pkg::MODE_BODY: begin
        if (b == anbs_pkg::BYTE_ONE && held_zeros >= 2) begin
          if (e) begin
            // a zero ahead of 00 00 01 stays data
            if (held_zeros == 3) take_byte(anbs_pkg::BYTE_ZERO);
            finish_unit();
            add_result(8'h00, 1'b0, 1'b0, 5'd0, anbs_pkg::ST_SHORT);
            rearm();
          end else begin
            finish_unit();
            held_zeros = 0;
          end
        end else if (b == anbs_pkg::BYTE_ZERO) begin
          if (e) begin
            zeros = (held_zeros >= 3) ? 3 : held_zeros + 1;
            for (int i = 0; i < zeros; i++) take_byte(anbs_pkg::BYTE_ZERO);
            finish_unit();
            rearm();
          end else if (held_zeros >= 3) begin
            take_byte(anbs_pkg::BYTE_ZERO);
          end else begin
            held_zeros++;
          end
        end else begin
          zeros = held_zeros;
          if (e && zeros == 3) zeros = 2;
          for (int i = 0; i < zeros; i++) take_byte(anbs_pkg::BYTE_ZERO);
          take_byte(b);
          held_zeros = 0;
          if (e) begin
            finish_unit();
            rearm();
          end
        end
      end
      anbs_pkg::MODE_DROP: begin
        if (e) rearm();
      end
      default: begin
        if (hdr_pos < 2) begin
          hdr[hdr_pos] = b;
          if (e) begin
            add_result(8'h00, 1'b0, 1'b0, 5'd0, anbs_pkg::ST_SHORT);
            rearm();
          end else begin
            hdr_pos++;
          end
        end else if (hdr_pos == 2) begin
          hdr[2] = b;
          if (e) begin
            add_result(8'h00, 1'b0, 1'b0, 5'd0, anbs_pkg::ST_SHORT);
            rearm();
          end else if ((hdr[0] | hdr[1]) != 8'h00) begin
            go_drop();
          end else if (b == anbs_pkg::BYTE_ONE) begin
            enter_unit();
          end else if (b == anbs_pkg::BYTE_ZERO) begin
            hdr_pos = 3;
          end else begin
            go_drop();
          end
        end else begin
          if (b == anbs_pkg::BYTE_ONE && !e) begin
            enter_unit();
          end else if (e) begin
            add_result(8'h00, 1'b0, 1'b0, 5'd0, anbs_pkg::ST_BAD);
            rearm();
          end else begin
            go_drop();
          end
        end
      end
    endcase
  endfunction

  task automatic flag_mismatch(string msg);
    $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
    beat_errs++;
  endtask

  // sample both handshakes at the rising edge
  always @(posedge clk) begin
    anbs_pkg::res_t want;
    if (rst_n && in_push && !in_full) begin
      parse_byte(in_byte, in_packet_end);
      case (row_kind)
        ROW_MODEL: for (int i = 0; i < found_n; i++) awaited_beats.push_back(found[i]);
        ROW_BAD, ROW_SHORT: begin
          want = '0;
          want.status = (row_kind == ROW_BAD) ? anbs_pkg::ST_BAD : anbs_pkg::ST_SHORT;
          awaited_beats.push_back(want);
        end
        default: ;
      endcase
    end
    if (rst_n && out_pop && !out_empty) begin
      if (awaited_beats.size() == 0) begin
        flag_mismatch($sformatf("byte %02h status %0d with nothing expected",
                                out_byte, out_status));
      end else begin
        want = awaited_beats.pop_front();
        if (out_byte !== want.data)
          flag_mismatch($sformatf("byte %02h, want %02h", out_byte, want.data));
        if (out_unit_first !== want.first)
          flag_mismatch($sformatf("unit_first %b, want %b", out_unit_first, want.first));
        if (out_unit_last !== want.last)
          flag_mismatch($sformatf("unit_last %b, want %b", out_unit_last, want.last));
        if (out_unit_type !== want.utype)
          flag_mismatch($sformatf("unit_type %0d, want %0d", out_unit_type, want.utype));
        if (out_status !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
      end
      results_seen++;
    end
  end

  // receiver stalls: heavy, then light, then none
  always @(negedge clk) begin
    if (beats_sent < 160) out_pop <= ($urandom_range(99) >= 61);
    else if (beats_sent < 320) out_pop <= ($urandom_range(99) >= 6);
    else out_pop <= 1'b1;
  end

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 35) return anbs_pkg::BYTE_ZERO;
    if (r < 50) return anbs_pkg::BYTE_ONE;
    if (r < 55) return 8'hFF;
    if (r < 60) return 8'h80;
    return 8'($urandom_range(255));
  endfunction

  // call at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_beat(logic [7:0] b, logic e, row_kind_t kind);
    int gap_pct;
    gap_pct = (beats_sent < 160) ? 6 : (beats_sent < 320) ? 61 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push       <= 1'b1;
    in_byte       <= b;
    in_packet_end <= e;
    row_kind      <= kind;
    @(posedge clk);
    while (in_full) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  initial begin
    script_row_t script [SCRIPT_LEN];
    logic [7:0]  pkt [$];
    int          r;
    int          body_len;

    script = '{
      // one-byte packet is too short
      '{8'hFF, 1'b1, ROW_SHORT},
      // three-byte packet, even a full start code, is too short
      '{8'h00, 1'b0, ROW_QUIET}, '{8'h00, 1'b0, ROW_QUIET}, '{8'h01, 1'b1, ROW_SHORT},
      // nonzero opening byte: bad start code, rest dropped
      '{8'h12, 1'b0, ROW_QUIET}, '{8'h00, 1'b0, ROW_QUIET}, '{8'h05, 1'b0, ROW_BAD},
      '{8'h07, 1'b1, ROW_QUIET},
      // fourth byte not 01
      '{8'h00, 1'b0, ROW_QUIET}, '{8'h00, 1'b0, ROW_QUIET}, '{8'h00, 1'b0, ROW_QUIET},
      '{8'h02, 1'b1, ROW_BAD},
      // four-byte start code with nothing after it
      '{8'h00, 1'b0, ROW_QUIET}, '{8'h00, 1'b0, ROW_QUIET}, '{8'h00, 1'b0, ROW_QUIET},
      '{8'h01, 1'b1, ROW_BAD},
      // good packet: unit FF, 00 00 00 01 split, unit of a single zero
      '{8'h00, 1'b0, ROW_QUIET}, '{8'h00, 1'b0, ROW_QUIET}, '{8'h01, 1'b0, ROW_QUIET},
      '{8'hFF, 1'b0, ROW_MODEL}, '{8'h00, 1'b0, ROW_MODEL}, '{8'h00, 1'b0, ROW_MODEL},
      '{8'h00, 1'b0, ROW_MODEL}, '{8'h01, 1'b0, ROW_MODEL}, '{8'h00, 1'b1, ROW_MODEL}
    };

    rst_n         = 1'b0;
    in_push       = 1'b0;
    in_byte       = 8'h00;
    in_packet_end = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (script[i]) send_beat(script[i].b, script[i].e, script[i].kind);

    while (beats_sent < SCRIPT_LEN + RANDOM_BEATS) begin
      pkt = {};
      r = $urandom_range(99);
      if (r < 70) begin
        // well formed: start code, then a unit with start codes mixed in
        if ($urandom_range(1)) pkt.push_back(anbs_pkg::BYTE_ZERO);
        pkt.push_back(anbs_pkg::BYTE_ZERO);
        pkt.push_back(anbs_pkg::BYTE_ZERO);
        pkt.push_back(anbs_pkg::BYTE_ONE);
        body_len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
        repeat (body_len) begin
          if ($urandom_range(99) < 12) begin
            if ($urandom_range(1)) pkt.push_back(anbs_pkg::BYTE_ZERO);
            pkt.push_back(anbs_pkg::BYTE_ZERO);
            pkt.push_back(anbs_pkg::BYTE_ZERO);
            pkt.push_back(anbs_pkg::BYTE_ONE);
          end else begin
            pkt.push_back(pick_byte());
          end
        end
      end else if (r < 80) begin
        // start code, mostly broken near its end
        pkt.push_back(anbs_pkg::BYTE_ZERO);
        pkt.push_back(anbs_pkg::BYTE_ZERO);
        if ($urandom_range(1)) pkt.push_back(anbs_pkg::BYTE_ZERO);
        repeat ($urandom_range(1, 4)) pkt.push_back(pick_byte());
      end else if (r < 90) begin
        repeat ($urandom_range(1, 3)) pkt.push_back(pick_byte());
      end else begin
        repeat ($urandom_range(1, 15)) pkt.push_back(pick_byte());
      end
      foreach (pkt[i]) send_beat(pkt[i], (i == pkt.size() - 1), ROW_MODEL);
    end
    in_push <= 1'b0;

    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (awaited_beats.size() != 0) flag_mismatch("expected results left over");
    if (beat_errs == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/anbs_pkg.sv
sv/anbs_front.sv
sv/anbs_back.sv
sv/annexb_nal_splitter.sv
sim/annexb_nal_splitter_tb.sv
